// ===== rtl/core/lmbs_pkg.sv =====
// Shared types and constants for the LED matrix bitmap scroller.
// Used by the divider, the frame builder, the top level and the checker.
package lmbs_pkg;

  localparam int ImgW   = 64;
  localparam int TimeW  = 32;
  localparam int ShiftW = 4;

  // Request operation codes.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_IMAGE  = 2'd0;
  localparam logic [1:0] REG_PERIOD = 2'd1;
  localparam logic [1:0] REG_LEFT   = 2'd2;
  localparam logic [1:0] REG_WRAP   = 2'd3;

  localparam logic signed [ShiftW-1:0] SHIFT_MAX = 4'sd7;
  localparam logic signed [ShiftW-1:0] SHIFT_MIN = -4'sd7;

  // Result of one elapsed-time division.
  typedef struct packed {
    logic             done;
    logic             nonzero;
    logic [2:0]       mod8;
    logic [3:0]       mod15;
    logic [TimeW-1:0] rem;
  } div_res_t;

endpackage

// ===== rtl/core/lmbs_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Returns the remainder and the quotient reduced mod 8 and mod 15. Depends on lmbs_pkg.
module lmbs_divider import lmbs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [TimeW-1:0] dividend,
  input  logic [TimeW-1:0] divisor,
  output div_res_t         res
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [TimeW-1:0] dvd_r, dvd_nxt;
  logic [TimeW-1:0] dvs_r, dvs_nxt;
  logic [TimeW-1:0] rem_r, rem_nxt;
  logic             nz_r, nz_nxt;
  logic [2:0]       m8_r, m8_nxt;
  logic [3:0]       m15_r, m15_nxt;

  logic [TimeW:0]   trial;
  logic [TimeW:0]   diff;
  logic             qbit;
  logic [4:0]       m15_dbl;

  always_comb begin
    trial = {rem_r, dvd_r[TimeW-1]};
    diff  = trial - {1'b0, dvs_r};
    qbit  = (trial >= {1'b0, dvs_r});
    // Running residue of the quotient mod 15, built MSB first.
    m15_dbl = {m15_r, qbit};
    if (m15_dbl >= 5'd15) begin
      m15_dbl = m15_dbl - 5'd15;
    end

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    nz_nxt   = nz_r;
    m8_nxt   = m8_r;
    m15_nxt  = m15_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd31;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      nz_nxt   = 1'b0;
      m8_nxt   = '0;
      m15_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[TimeW-2:0], 1'b0};
      rem_nxt = qbit ? diff[TimeW-1:0] : trial[TimeW-1:0];
      nz_nxt  = nz_r | qbit;
      m8_nxt  = {m8_r[1:0], qbit};
      m15_nxt = m15_dbl[3:0];
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    nz_r  <= nz_nxt;
    m8_r  <= m8_nxt;
    m15_r <= m15_nxt;
  end

  assign res.done    = done_r;
  assign res.nonzero = nz_r;
  assign res.mod8    = m8_r;
  assign res.mod15   = m15_r;
  assign res.rem     = rem_r;

endmodule

// ===== rtl/core/lmbs_frame.sv =====
// Frame builder: rotates or shifts each row of the image by the column shift.
// Depends on lmbs_pkg.
module lmbs_frame import lmbs_pkg::*; (
  input  logic [ImgW-1:0]   image,
  input  logic [ShiftW-1:0] shift,
  input  logic              wrap,
  output logic [ImgW-1:0]   pixels
);

  logic [ShiftW-1:0] neg_shift;

  assign neg_shift = ~shift + 4'd1;

  always_comb begin
    logic [7:0]  b;
    logic [15:0] rot;
    pixels = '0;
    for (int row = 0; row < 8; row++) begin
      b   = image[8*row +: 8];
      rot = {b, b} >> shift[2:0];
      if (wrap) begin
        pixels[8*row +: 8] = rot[7:0];
      end else if (!shift[3]) begin
        pixels[8*row +: 8] = b >> shift[2:0];
      end else if (neg_shift[3]) begin
        pixels[8*row +: 8] = 8'd0;
      end else begin
        pixels[8*row +: 8] = b << neg_shift[2:0];
      end
    end
  end

endmodule

// ===== rtl/core/led_matrix_bitmap_scroller.sv =====
// A tick request is accepted, the one-bit-per-cycle divider splits elapsed time
// into whole step periods, the step count is folded into the shift, and the
// output register is loaded; a tick that advances no step with no frame pending
// returns to idle. Stop requests queue a blank frame; new requests wait until done.
// Synchronous active-low reset clears all control state and returns the
// configuration registers to image 0, period 1, scroll right, no wrap.
module led_matrix_bitmap_scroller import lmbs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_operation,
  input  logic [TimeW-1:0]  in_now_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ImgW-1:0]   out_pixels,
  output logic [ShiftW-1:0] out_column_shift,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [ImgW-1:0]   cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FOLD = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [ImgW-1:0]   image_r;
  logic [TimeW-1:0]  period_r;
  logic              left_r, wrap_r;
  logic              running_r, running_nxt;
  logic              pending_r, pending_nxt;
  logic [ShiftW-1:0] shift_r, shift_nxt;
  logic [TimeW-1:0]  last_r, last_nxt;
  logic [TimeW-1:0]  now_r, now_nxt;
  logic              blank_r, blank_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ImgW-1:0]   out_pix_r, out_pix_nxt;
  logic [ShiftW-1:0] out_sh_r, out_sh_nxt;

  logic              in_fire;
  logic              div_start;
  logic [TimeW-1:0]  divisor;
  div_res_t          div_res;
  logic [ImgW-1:0]   frame;

  logic [2:0]        w3;
  logic [4:0]        sv;
  logic [4:0]        t15;
  logic [ShiftW-1:0] folded;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign divisor   = (period_r == '0) ? 32'd1 : period_r;
  assign div_start = in_fire && (in_operation == OP_TICK) && running_r;

  lmbs_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_now_ms - last_r),
    .divisor  (divisor),
    .res      (div_res)
  );

  lmbs_frame u_frame (
    .image  (image_r),
    .shift  (shift_r),
    .wrap   (wrap_r),
    .pixels (frame)
  );

  // Advance the shift by the step count, folded mod 8 or mod 15.
  always_comb begin
    w3 = left_r ? (shift_r[2:0] - div_res.mod8) : (shift_r[2:0] + div_res.mod8);
    sv = {shift_r[3], shift_r} + 5'd7;
    if (sv[4]) begin
      sv = 5'd0;
    end else if (sv > 5'd14) begin
      sv = 5'd14;
    end
    t15 = left_r ? (sv + 5'd15 - {1'b0, div_res.mod15}) : (sv + {1'b0, div_res.mod15});
    if (t15 >= 5'd15) begin
      t15 = t15 - 5'd15;
    end
    t15 = t15 - 5'd7;
    folded = wrap_r ? {1'b0, w3} : t15[3:0];
  end

  always_comb begin
    state_nxt     = state_r;
    running_nxt   = running_r;
    pending_nxt   = pending_r;
    shift_nxt     = shift_r;
    last_nxt      = last_r;
    now_nxt       = now_r;
    blank_nxt     = blank_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_pix_nxt   = out_pix_r;
    out_sh_nxt    = out_sh_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_operation)
            OP_START: begin
              running_nxt = 1'b1;
              pending_nxt = 1'b1;
              last_nxt    = in_now_ms;
              shift_nxt   = wrap_r ? '0 : (left_r ? SHIFT_MAX : SHIFT_MIN);
            end
            OP_STOP: begin
              running_nxt = 1'b0;
              pending_nxt = 1'b0;
              shift_nxt   = '0;
              last_nxt    = '0;
              blank_nxt   = 1'b1;
              state_nxt   = ST_EMIT;
            end
            OP_TICK: begin
              if (running_r) begin
                now_nxt   = in_now_ms;
                blank_nxt = 1'b0;
                state_nxt = ST_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (div_res.nonzero) begin
          last_nxt  = now_r - div_res.rem;
          shift_nxt = folded;
          state_nxt = ST_EMIT;
        end else if (pending_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = blank_r ? '0 : frame;
          out_sh_nxt    = shift_r;
          pending_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      running_r   <= 1'b0;
      pending_r   <= 1'b0;
      shift_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
      image_r     <= '0;
      period_r    <= 32'd1;
      left_r      <= 1'b0;
      wrap_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      pending_r   <= pending_nxt;
      shift_r     <= shift_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_IMAGE:  image_r  <= cfg_data;
          REG_PERIOD: period_r <= cfg_data[TimeW-1:0];
          REG_LEFT:   left_r   <= cfg_data[0];
          REG_WRAP:   wrap_r   <= cfg_data[0];
          default: ;
        endcase
      end
    end
    now_r     <= now_nxt;
    blank_r   <= blank_nxt;
    out_pix_r <= out_pix_nxt;
    out_sh_r  <= out_sh_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pixels       = out_pix_r;
  assign out_column_shift = out_sh_r;

endmodule

// ===== rtl/core/lmbs_checker.sv =====
// Port-level checks for the LED matrix bitmap scroller, bound to the top level.
// Depends on lmbs_pkg.
module lmbs_checker import lmbs_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [1:0]        in_operation,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ImgW-1:0]   out_pixels,
  input logic [ShiftW-1:0] out_column_shift
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixels) && $stable(out_column_shift))
    else $error("result changed while stalled");

  // A stop request blocks new requests until its blank frame is queued.
  a_stop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_STOP |=> !in_ready)
    else $error("request accepted right after stop");

  // The shift never takes the value -8.
  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_column_shift != 4'b1000)
    else $error("column shift out of range");

  // Reset leaves the block idle and ready.
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind led_matrix_bitmap_scroller lmbs_checker u_lmbs_checker (.*);
